### hw/rtl/tma_pkg.sv
// ----------------------------------------------------------------------------
// tma_pkg
// Shared types and constants of the trimmed moving-average filter.
// ----------------------------------------------------------------------------
package tma_pkg;

  localparam int DEF_WINDOW      = 8;
  localparam int DEF_CHANNELS    = 8;
  localparam int DEF_SAMPLE_BITS = 12;

  localparam int CH_W        = 3;
  localparam int IN_SAMPLE_W = 12;
  localparam int AVG_W       = 12;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic                   ok;
    logic [CH_W-1:0]        ch;
    logic [IN_SAMPLE_W-1:0] smp;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_LAST,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

### hw/rtl/trimmed_moving_average.sv
// ----------------------------------------------------------------------------
// trimmed_moving_average
// Per-channel sliding-window filter: plain mean while a channel's window
// fills, mean without the largest and smallest sample once it is full.
// ----------------------------------------------------------------------------
// For each accepted sample on a valid channel, the back end makes n
// window-store reads, one per stored sample, n being the channel's fill
// count after the sample (at most WINDOW), then a divider retires one
// quotient bit per cycle.
// A two-entry queue takes input transfers while the back end works, and the
// result register holds one result until it is popped. The window store
// needs no clearing pass: only entries below the fill count are read.
module trimmed_moving_average import tma_pkg::*; #(
  parameter int WINDOW      = DEF_WINDOW,
  parameter int CHANNELS    = DEF_CHANNELS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [CH_W-1:0]        in_channel,
  input  logic [IN_SAMPLE_W-1:0] in_sample,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [CH_W-1:0]        out_channel,
  output logic [AVG_W-1:0]       out_average,
  output logic                   out_window_full
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  tma_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_channel (in_channel),
    .in_sample  (in_sample),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  tma_back #(
    .WINDOW      (WINDOW),
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_channel     (out_channel),
    .out_average     (out_average),
    .out_window_full (out_window_full)
  );

endmodule

### hw/rtl/tma_front.sv
// ----------------------------------------------------------------------------
// tma_front
// Accepts input transfers, flags channels outside the configured range and
// holds the items in a short queue for the back end.
// ----------------------------------------------------------------------------
module tma_front import tma_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [CH_W-1:0]        in_channel,
  input  logic [IN_SAMPLE_W-1:0] in_sample,
  output logic                   q_valid,
  output item_t                  q_item,
  input  logic                   q_pop
);

  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t               queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                push_ok;
  logic                pop_ok;
  item_t               new_item;

  assign in_full = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = queue_r[rd_ptr_r];
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_pop && q_valid;

  always_comb begin
    new_item.ok  = (32'(in_channel) < CHANNELS);
    new_item.ch  = in_channel;
    new_item.smp = in_sample;
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      queue_r[wr_ptr_r] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count_r <= count_r + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/tma_back.sv
// ----------------------------------------------------------------------------
// tma_back
// Per-channel window store, window walk for sum and extremes, bit-serial
// divider and the result register.
// ----------------------------------------------------------------------------
module tma_back import tma_pkg::*; #(
  parameter int WINDOW      = DEF_WINDOW,
  parameter int CHANNELS    = DEF_CHANNELS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  item_t            q_item,
  output logic             q_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [CH_W-1:0]  out_channel,
  output logic [AVG_W-1:0] out_average,
  output logic             out_window_full
);

  localparam int CIDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW     = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int DCNT_W = $clog2(SUM_W);
  localparam int AW     = CIDX_W + PW;
  localparam int DEPTH  = CHANNELS << PW;

  state_t state_r;
  state_t state_nxt;

  logic [SAMPLE_BITS-1:0] mem_r [DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data_r;

  logic [CNT_W-1:0]       cnt_r [CHANNELS];
  logic [PW-1:0]          ptr_r [CHANNELS];

  logic [CH_W-1:0]        ch_r;
  logic [CIDX_W-1:0]      cidx_r;
  logic [SAMPLE_BITS-1:0] smp_r;
  logic                   ok_r;
  logic [CNT_W-1:0]       n_r;
  logic [PW-1:0]          k_r;
  logic                   rd_vld_r;
  logic                   first_r;
  logic                   full_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SAMPLE_BITS-1:0] hi_r;
  logic [SAMPLE_BITS-1:0] lo_r;
  logic [CNT_W-1:0]       div_r;
  logic [CNT_W-1:0]       rem_r;
  logic [SUM_W-1:0]       quo_r;
  logic [DCNT_W-1:0]      dcnt_r;

  logic                   out_valid_r;
  logic [CH_W-1:0]        out_ch_r;
  logic [AVG_W-1:0]       out_avg_r;
  logic                   out_full_r;

  logic                   mem_we;
  logic                   rd_en;
  logic                   out_load;
  logic                   last_read;
  logic [CNT_W-1:0]       cur_cnt;
  logic [CNT_W-1:0]       new_cnt;
  logic [PW-1:0]          cur_ptr;
  logic [CNT_W:0]         rem_sh;
  logic                   rem_ge;

  assign cur_cnt   = cnt_r[cidx_r];
  assign cur_ptr   = ptr_r[cidx_r];
  assign new_cnt   = (cur_cnt < CNT_W'(WINDOW)) ? cur_cnt + 1'b1 : cur_cnt;
  assign last_read = ((CNT_W'(k_r) + CNT_W'(1)) == n_r);
  assign rem_sh    = {rem_r, quo_r[SUM_W-1]};
  assign rem_ge    = (rem_sh >= {1'b0, div_r});

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (q_valid) state_nxt = q_item.ok ? ST_WRITE : ST_DONE;
      ST_WRITE: state_nxt = ST_READ;
      ST_READ:  if (last_read) state_nxt = ST_LAST;
      ST_LAST:  state_nxt = ST_PREP;
      ST_PREP:  state_nxt = ST_DIV;
      ST_DIV:   if (dcnt_r == '0) state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || out_pop) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop    = 1'b0;
    mem_we   = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE:  q_pop = q_valid;
      ST_WRITE: mem_we = 1'b1;
      ST_READ:  rd_en = 1'b1;
      ST_DONE:  out_load = !out_valid_r || out_pop;
      default:  q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // window store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[AW'({cidx_r, cur_ptr})] <= smp_r;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[AW'({cidx_r, k_r})];
    end
  end

  // fill counts and write pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        cnt_r[c] <= '0;
        ptr_r[c] <= '0;
      end
    end else if (mem_we) begin
      cnt_r[cidx_r] <= new_cnt;
      ptr_r[cidx_r] <= (cur_ptr == PW'(WINDOW - 1)) ? '0 : cur_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ch_r   <= q_item.ch;
      cidx_r <= CIDX_W'(q_item.ch);
      smp_r  <= SAMPLE_BITS'(q_item.smp);
      ok_r   <= q_item.ok;
    end
    if (mem_we) begin
      n_r     <= new_cnt;
      full_r  <= (new_cnt == CNT_W'(WINDOW));
      k_r     <= '0;
      first_r <= 1'b1;
      sum_r   <= '0;
    end
    if (rd_en) begin
      k_r <= k_r + 1'b1;
    end
    if (rd_vld_r) begin
      sum_r   <= sum_r + SUM_W'(rd_data_r);
      first_r <= 1'b0;
      if (first_r || rd_data_r > hi_r) begin
        hi_r <= rd_data_r;
      end
      if (first_r || rd_data_r < lo_r) begin
        lo_r <= rd_data_r;
      end
    end
    if (state_r == ST_PREP) begin
      quo_r  <= full_r ? sum_r - SUM_W'(hi_r) - SUM_W'(lo_r) : sum_r;
      div_r  <= full_r ? CNT_W'(WINDOW - 2) : n_r;
      rem_r  <= '0;
      dcnt_r <= DCNT_W'(SUM_W - 1);
    end
    if (state_r == ST_DIV) begin
      rem_r  <= rem_ge ? CNT_W'(rem_sh - {1'b0, div_r}) : CNT_W'(rem_sh);
      quo_r  <= {quo_r[SUM_W-2:0], rem_ge};
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch_r   <= ch_r;
      out_avg_r  <= ok_r ? AVG_W'(quo_r) : '0;
      out_full_r <= ok_r && full_r;
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_channel     = out_ch_r;
  assign out_average     = out_avg_r;
  assign out_window_full = out_full_r;

endmodule
